FILE: rtl/bxd_pkg.sv
package bxd_pkg;

   // Sizes of the datapath
   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;
   localparam int FRAC_BITS  = 8;
   localparam int CFG_W      = 13;
   localparam int CH_W       = 8;
   localparam int NUM_CH     = 4;
   localparam int OUT_XY_W   = 12;
   localparam int CSR_IDX_W  = 2;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int COLC_W = COL_W + 1;
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int ROWC_W = ROW_W + 1;
   localparam int DIM_MAX_W = (COLC_W > ROWC_W) ? COLC_W : ROWC_W;
   localparam int EDGE_W_A  = DIM_MAX_W + FRAC_BITS + 1;
   localparam int EDGE_W    = (EDGE_W_A > CFG_W + 1) ? EDGE_W_A : CFG_W + 1;

   // Box side in source pixels is at most ceil(scale)
   localparam int SPAN_W = (CFG_W > FRAC_BITS) ? CFG_W - FRAC_BITS + 1 : 2;
   localparam int CNT_W  = 2 * SPAN_W;
   localparam int SUM_W  = CNT_W + CH_W;
   localparam int STEP_W = $clog2(CH_W);

   localparam logic [CFG_W-1:0] SCALE_ONE    = CFG_W'(1 << FRAC_BITS);
   localparam logic [CFG_W-1:0] RESET_SCALE  = CFG_W'(512);
   localparam logic [CFG_W-1:0] RESET_WIDTH  = CFG_W'(640);
   localparam logic [CFG_W-1:0] RESET_HEIGHT = CFG_W'(480);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = CSR_IDX_W'(2);

   typedef struct packed {
      logic                active;
      logic                first;
      logic                emit;
      logic                frame_done;
      logic [COL_W-1:0]    addr;
      logic [CNT_W-1:0]    cnt;
      logic [OUT_XY_W-1:0] out_x;
      logic [OUT_XY_W-1:0] out_y;
   } walk_ctl_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

endpackage

FILE: rtl/bxd_sum_ram.sv
module bxd_sum_ram #(
   parameter int ADDR_W = 12,
   parameter int DATA_W = 80
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Forward a same-cycle write to the same entry
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/bxd_divider.sv
module bxd_divider (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   input  logic [bxd_pkg::NUM_CH*bxd_pkg::SUM_W-1:0] dividend,
   input  logic [bxd_pkg::CNT_W-1:0]                divisor,
   input  logic                                     take,
   output logic                                     busy,
   output logic                                     done,
   output logic [bxd_pkg::NUM_CH*bxd_pkg::CH_W-1:0]  quotient
);

   localparam int CNT_W  = bxd_pkg::CNT_W;
   localparam int CH_W   = bxd_pkg::CH_W;
   localparam int SUM_W  = bxd_pkg::SUM_W;
   localparam int NUM_CH = bxd_pkg::NUM_CH;
   localparam int STEP_W = bxd_pkg::STEP_W;

   bxd_pkg::div_state_type state_ff, state_in;

   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  divisor_ff;
   logic [CNT_W-1:0]  rem_ff [NUM_CH];
   logic [CNT_W-1:0]  rem_in [NUM_CH];
   logic [CH_W-1:0]   quo_ff [NUM_CH];
   logic [CH_W-1:0]   quo_in [NUM_CH];
   logic              last_step;

   assign last_step = (step_ff == STEP_W'(CH_W - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bxd_pkg::DIV_IDLE: if (start) state_in = bxd_pkg::DIV_RUN;
         bxd_pkg::DIV_RUN:  if (last_step) state_in = bxd_pkg::DIV_DONE;
         bxd_pkg::DIV_DONE: if (take) state_in = bxd_pkg::DIV_IDLE;
         default:           state_in = bxd_pkg::DIV_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      busy = 1'b0;
      done = 1'b0;
      unique case (state_ff)
         bxd_pkg::DIV_IDLE: busy = 1'b0;
         bxd_pkg::DIV_RUN:  busy = 1'b1;
         bxd_pkg::DIV_DONE: begin
            busy = 1'b1;
            done = 1'b1;
         end
         default:           busy = 1'b0;
      endcase
   end

   // One restoring step per cycle on every channel; the upper dividend bits
   // start below the divisor because each mean fits in one channel.
   always_comb begin
      logic [CNT_W:0] trial;
      logic           fits;
      trial = '0;
      fits  = 1'b0;
      step_in = step_ff;
      for (int c = 0; c < NUM_CH; c++) begin
         rem_in[c] = rem_ff[c];
         quo_in[c] = quo_ff[c];
      end
      if (start && (state_ff == bxd_pkg::DIV_IDLE)) begin
         step_in = '0;
         for (int c = 0; c < NUM_CH; c++) begin
            rem_in[c] = dividend[c*SUM_W+CH_W +: CNT_W];
            quo_in[c] = dividend[c*SUM_W +: CH_W];
         end
      end else if (state_ff == bxd_pkg::DIV_RUN) begin
         step_in = step_ff + STEP_W'(1);
         for (int c = 0; c < NUM_CH; c++) begin
            trial = {rem_ff[c], quo_ff[c][CH_W-1]};
            fits  = (trial >= {1'b0, divisor_ff});
            rem_in[c] = fits ? CNT_W'(trial - {1'b0, divisor_ff}) : CNT_W'(trial);
            quo_in[c] = {quo_ff[c][CH_W-2:0], fits};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bxd_pkg::DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      if (start && (state_ff == bxd_pkg::DIV_IDLE)) begin
         divisor_ff <= divisor;
      end
      for (int c = 0; c < NUM_CH; c++) begin
         rem_ff[c] <= rem_in[c];
         quo_ff[c] <= quo_in[c];
      end
   end

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         quotient[c*CH_W +: CH_W] = quo_ff[c];
      end
   end

endmodule

FILE: rtl/bxd_walker.sv
module bxd_walker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [bxd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bxd_pkg::CFG_W-1:0]         csr_data,
   input  logic                              accept,
   output bxd_pkg::walk_ctl_type             ctl
);

   localparam int CFG_W     = bxd_pkg::CFG_W;
   localparam int COL_W     = bxd_pkg::COL_W;
   localparam int COLC_W    = bxd_pkg::COLC_W;
   localparam int ROW_W     = bxd_pkg::ROW_W;
   localparam int ROWC_W    = bxd_pkg::ROWC_W;
   localparam int EDGE_W    = bxd_pkg::EDGE_W;
   localparam int SPAN_W    = bxd_pkg::SPAN_W;
   localparam int CNT_W     = bxd_pkg::CNT_W;
   localparam int FRAC_BITS = bxd_pkg::FRAC_BITS;
   localparam int OUT_XY_W  = bxd_pkg::OUT_XY_W;

   function automatic logic [EDGE_W-1:0] eff_scale(input logic [CFG_W-1:0] raw);
      return (raw < bxd_pkg::SCALE_ONE) ? EDGE_W'(bxd_pkg::SCALE_ONE) : EDGE_W'(raw);
   endfunction

   logic [CFG_W-1:0]  scale_ff, scale_in;
   logic [CFG_W-1:0]  width_ff, width_in;
   logic [CFG_W-1:0]  height_ff, height_in;
   logic [COL_W-1:0]  src_col_ff, src_col_in;
   logic [ROW_W-1:0]  src_row_ff, src_row_in;
   logic [COLC_W-1:0] box_col_ff, box_col_in;
   logic [COLC_W-1:0] col_start_ff, col_start_in;
   logic [EDGE_W-1:0] col_edge_ff, col_edge_in;
   logic [ROWC_W-1:0] box_row_ff, box_row_in;
   logic [ROWC_W-1:0] row_start_ff, row_start_in;
   logic [EDGE_W-1:0] row_edge_ff, row_edge_in;

   logic [EDGE_W-1:0] s_eff, s_new;
   logic [COLC_W-1:0] w_eff;
   logic [ROWC_W-1:0] h_eff;
   logic [EDGE_W-1:0] w_lim, h_lim;
   logic [EDGE_W-1:0] col_end, row_end;
   logic [SPAN_W-1:0] col_span, row_span;
   logic              col_fits, row_fits, active;
   logic              last_col, last_row, col_wrap, row_wrap;

   assign s_eff = eff_scale(scale_ff);

   // Clamp width to 1..MAX_WIDTH and height to 1..MAX_HEIGHT
   always_comb begin
      if (width_ff == '0) begin
         w_eff = COLC_W'(1);
      end else if (32'(width_ff) > 32'(bxd_pkg::MAX_WIDTH)) begin
         w_eff = COLC_W'(bxd_pkg::MAX_WIDTH);
      end else begin
         w_eff = COLC_W'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = ROWC_W'(1);
      end else if (32'(height_ff) > 32'(bxd_pkg::MAX_HEIGHT)) begin
         h_eff = ROWC_W'(bxd_pkg::MAX_HEIGHT);
      end else begin
         h_eff = ROWC_W'(height_ff);
      end
   end

   // A box lies inside the image when its right (bottom) edge does
   assign w_lim    = EDGE_W'(w_eff) << FRAC_BITS;
   assign h_lim    = EDGE_W'(h_eff) << FRAC_BITS;
   assign col_fits = (col_edge_ff <= w_lim);
   assign row_fits = (row_edge_ff <= h_lim);
   assign active   = col_fits && row_fits;

   assign col_end  = col_edge_ff >> FRAC_BITS;
   assign row_end  = row_edge_ff >> FRAC_BITS;
   assign last_col = ((EDGE_W'(src_col_ff) + EDGE_W'(1)) == col_end);
   assign last_row = ((EDGE_W'(src_row_ff) + EDGE_W'(1)) == row_end);
   assign col_wrap = ((COLC_W'(src_col_ff) + COLC_W'(1)) >= w_eff);
   assign row_wrap = ((ROWC_W'(src_row_ff) + ROWC_W'(1)) >= h_eff);

   assign col_span = SPAN_W'(col_end - EDGE_W'(col_start_ff));
   assign row_span = SPAN_W'(row_end - EDGE_W'(row_start_ff));

   always_comb begin
      ctl.active     = active;
      ctl.first      = (COLC_W'(src_col_ff) == col_start_ff) &&
                       (ROWC_W'(src_row_ff) == row_start_ff);
      ctl.emit       = active && last_col && last_row;
      ctl.frame_done = active && ((row_edge_ff + s_eff) > h_lim) &&
                       ((col_edge_ff + s_eff) > w_lim);
      ctl.addr       = box_col_ff[COL_W-1:0];
      ctl.cnt        = CNT_W'(col_span) * CNT_W'(row_span);
      ctl.out_x      = OUT_XY_W'(box_col_ff);
      ctl.out_y      = OUT_XY_W'(box_row_ff);
   end

   always_comb begin
      scale_in     = scale_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      src_col_in   = src_col_ff;
      src_row_in   = src_row_ff;
      box_col_in   = box_col_ff;
      col_start_in = col_start_ff;
      col_edge_in  = col_edge_ff;
      box_row_in   = box_row_ff;
      row_start_in = row_start_ff;
      row_edge_in  = row_edge_ff;
      s_new        = s_eff;
      if (csr_write) begin
         unique case (csr_index)
            bxd_pkg::CSR_SCALE:  scale_in  = csr_data;
            bxd_pkg::CSR_WIDTH:  width_in  = csr_data;
            bxd_pkg::CSR_HEIGHT: height_in = csr_data;
            default:             scale_in  = scale_ff;
         endcase
         // Any write restarts the frame with the new scale
         s_new        = eff_scale(scale_in);
         src_col_in   = '0;
         src_row_in   = '0;
         box_col_in   = '0;
         col_start_in = '0;
         col_edge_in  = s_new;
         box_row_in   = '0;
         row_start_in = '0;
         row_edge_in  = s_new;
      end else if (accept) begin
         if (active && last_col) begin
            box_col_in   = box_col_ff + COLC_W'(1);
            col_start_in = COLC_W'(col_end);
            col_edge_in  = col_edge_ff + s_eff;
         end
         src_col_in = src_col_ff + COL_W'(1);
         if (col_wrap) begin
            box_col_in   = '0;
            col_start_in = '0;
            col_edge_in  = s_eff;
            if (row_fits && last_row) begin
               box_row_in   = box_row_ff + ROWC_W'(1);
               row_start_in = ROWC_W'(row_end);
               row_edge_in  = row_edge_ff + s_eff;
            end
            src_col_in = '0;
            src_row_in = src_row_ff + ROW_W'(1);
            if (row_wrap) begin
               src_row_in   = '0;
               box_row_in   = '0;
               row_start_in = '0;
               row_edge_in  = s_eff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff     <= bxd_pkg::RESET_SCALE;
         width_ff     <= bxd_pkg::RESET_WIDTH;
         height_ff    <= bxd_pkg::RESET_HEIGHT;
         src_col_ff   <= '0;
         src_row_ff   <= '0;
         box_col_ff   <= '0;
         col_start_ff <= '0;
         col_edge_ff  <= eff_scale(bxd_pkg::RESET_SCALE);
         box_row_ff   <= '0;
         row_start_ff <= '0;
         row_edge_ff  <= eff_scale(bxd_pkg::RESET_SCALE);
      end else begin
         scale_ff     <= scale_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         src_col_ff   <= src_col_in;
         src_row_ff   <= src_row_in;
         box_col_ff   <= box_col_in;
         col_start_ff <= col_start_in;
         col_edge_ff  <= col_edge_in;
         box_row_ff   <= box_row_in;
         row_start_ff <= row_start_in;
         row_edge_ff  <= row_edge_in;
      end
   end

endmodule

FILE: rtl/box_average_downscaler.sv
// Box-average downscaler: RGBA pixels stream in raster order and each output
// pixel is the truncated mean of its source box, with the box size set by a
// 5.8 scale factor (1.0 and up, values below 1.0 act as 1.0). Pixels that do
// not finish a box are taken one per clock while no box result is being
// finished or divided; the per-column sums live in one synchronous RAM that
// is read when a pixel is taken and written back in the next cycle, with a
// bypass when back-to-back pixels hit the same column. A pixel that completes
// a box holds the input off while its sum is finished, while a shared
// bit-per-cycle divider works all four channels at once, and until the result
// is loaded into the output register, which waits while the output is stalled.
// A finished result waits in the output register while new pixels keep
// flowing. A write to any register, also one beyond the register list,
// restarts the frame at the top-left corner.
// Column sums need no clearing: the first pixel of every box overwrites its
// entry. csr_ready is always high; write registers only while idle.
module box_average_downscaler (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [bxd_pkg::CH_W-1:0]        req_red,
   input  logic [bxd_pkg::CH_W-1:0]        req_green,
   input  logic [bxd_pkg::CH_W-1:0]        req_blue,
   input  logic [bxd_pkg::CH_W-1:0]        req_alpha,

   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [bxd_pkg::OUT_XY_W-1:0]    rsp_out_x,
   output logic [bxd_pkg::OUT_XY_W-1:0]    rsp_out_y,
   output logic [bxd_pkg::CH_W-1:0]        rsp_avg_red,
   output logic [bxd_pkg::CH_W-1:0]        rsp_avg_green,
   output logic [bxd_pkg::CH_W-1:0]        rsp_avg_blue,
   output logic [bxd_pkg::CH_W-1:0]        rsp_avg_alpha,
   output logic                            rsp_frame_done,

   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bxd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bxd_pkg::CFG_W-1:0]       csr_data
);

   localparam int CH_W     = bxd_pkg::CH_W;
   localparam int NUM_CH   = bxd_pkg::NUM_CH;
   localparam int SUM_W    = bxd_pkg::SUM_W;
   localparam int CNT_W    = bxd_pkg::CNT_W;
   localparam int OUT_XY_W = bxd_pkg::OUT_XY_W;
   localparam int RAM_W    = NUM_CH * SUM_W;

   bxd_pkg::walk_ctl_type walk_ctl;
   bxd_pkg::walk_ctl_type b_ctl_ff;

   logic                  req_accept;
   logic                  b_valid_ff;
   logic [NUM_CH*CH_W-1:0] b_px_ff;
   logic [RAM_W-1:0]      rd_sums;
   logic [RAM_W-1:0]      new_sums;
   logic                  sum_write;
   logic                  div_start;
   logic                  div_busy;
   logic                  div_done;
   logic                  div_take;
   logic [NUM_CH*CH_W-1:0] quotient;

   logic [OUT_XY_W-1:0]   meta_x_ff;
   logic [OUT_XY_W-1:0]   meta_y_ff;
   logic                  meta_done_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_XY_W-1:0]   rsp_x_ff;
   logic [OUT_XY_W-1:0]   rsp_y_ff;
   logic [NUM_CH*CH_W-1:0] rsp_avg_ff;
   logic                  rsp_done_ff;

   // Hold the input while a box result is being finished or divided
   assign req_stall  = div_busy || (b_valid_ff && b_ctl_ff.emit);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   bxd_walker u_walker (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .accept    (req_accept),
      .ctl       (walk_ctl)
   );

   // Accumulate stage: the RAM read issued at transfer returns here
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         b_ctl_ff <= walk_ctl;
         b_px_ff  <= {req_alpha, req_blue, req_green, req_red};
      end
   end

   // Start a new sum on the first pixel of a box, else add to the stored one
   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         if (b_ctl_ff.first) begin
            new_sums[c*SUM_W +: SUM_W] = SUM_W'(b_px_ff[c*CH_W +: CH_W]);
         end else begin
            new_sums[c*SUM_W +: SUM_W] = rd_sums[c*SUM_W +: SUM_W] +
                                         SUM_W'(b_px_ff[c*CH_W +: CH_W]);
         end
      end
   end

   assign sum_write = b_valid_ff && b_ctl_ff.active;
   assign div_start = b_valid_ff && b_ctl_ff.emit;

   bxd_sum_ram #(
      .ADDR_W (bxd_pkg::COL_W),
      .DATA_W (RAM_W)
   ) u_sum_ram (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (walk_ctl.addr),
      .rd_data (rd_sums),
      .wr_en   (sum_write),
      .wr_addr (b_ctl_ff.addr),
      .wr_data (new_sums)
   );

   bxd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (new_sums),
      .divisor  (b_ctl_ff.cnt),
      .take     (div_take),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quotient)
   );

   // Hold the box position while the divider runs
   always_ff @(posedge clock) begin
      if (div_start) begin
         meta_x_ff    <= b_ctl_ff.out_x;
         meta_y_ff    <= b_ctl_ff.out_y;
         meta_done_ff <= b_ctl_ff.frame_done;
      end
   end

   // Output register: load when empty or when its transfer completes
   assign div_take = div_done && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (div_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (div_take) begin
         rsp_x_ff    <= meta_x_ff;
         rsp_y_ff    <= meta_y_ff;
         rsp_done_ff <= meta_done_ff;
         rsp_avg_ff  <= quotient;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_x      = rsp_x_ff;
   assign rsp_out_y      = rsp_y_ff;
   assign rsp_avg_red    = rsp_avg_ff[0*CH_W +: CH_W];
   assign rsp_avg_green  = rsp_avg_ff[1*CH_W +: CH_W];
   assign rsp_avg_blue   = rsp_avg_ff[2*CH_W +: CH_W];
   assign rsp_avg_alpha  = rsp_avg_ff[3*CH_W +: CH_W];
   assign rsp_frame_done = rsp_done_ff;

endmodule

FILE: bench/tb_top.sv
module tb_top;

   localparam int CH_W       = bxd_pkg::CH_W;
   localparam int NUM_CH     = bxd_pkg::NUM_CH;
   localparam int CFG_W      = bxd_pkg::CFG_W;
   localparam int OUT_XY_W   = bxd_pkg::OUT_XY_W;
   localparam int CSR_IDX_W  = bxd_pkg::CSR_IDX_W;
   localparam int MAX_WIDTH  = bxd_pkg::MAX_WIDTH;
   localparam int MAX_HEIGHT = bxd_pkg::MAX_HEIGHT;
   localparam int FRAC_BITS  = bxd_pkg::FRAC_BITS;

   // Register index past the end of the list: the write changes no register
   // but still restarts the frame.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = CSR_IDX_W'(3);

   localparam int SETTLE_CYCLES  = 40;    // quiet time before a register write
   localparam int WATCHDOG_LIMIT = 3000;  // cycles without any transfer
   localparam int MAX_REPORTS    = 10;
   localparam int RANDOM_PIXELS  = 550;

   typedef struct {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] alpha;
      bit              hold_for_drain;  // present only once all results are in
   } pixel_type;

   typedef struct packed {
      logic [OUT_XY_W-1:0] out_x;
      logic [OUT_XY_W-1:0] out_y;
      logic [CH_W-1:0]     red;
      logic [CH_W-1:0]     green;
      logic [CH_W-1:0]     blue;
      logic [CH_W-1:0]     alpha;
      logic                frame_done;
   } box_avg_type;

   typedef enum logic [1:0] {
      PIX_NOISE,  // any value
      PIX_RAILS,  // each channel at 0 or 255
      PIX_WHITE   // every channel at 255, largest sums
   } pixel_style_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_SOME,
      STALL_MOST,
      STALL_BEAT
   } stall_mode_type;

   logic clock;
   logic reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [CH_W-1:0]      req_red   = '0;
   logic [CH_W-1:0]      req_green = '0;
   logic [CH_W-1:0]      req_blue  = '0;
   logic [CH_W-1:0]      req_alpha = '0;

   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [OUT_XY_W-1:0]  rsp_out_x;
   logic [OUT_XY_W-1:0]  rsp_out_y;
   logic [CH_W-1:0]      rsp_avg_red;
   logic [CH_W-1:0]      rsp_avg_green;
   logic [CH_W-1:0]      rsp_avg_blue;
   logic [CH_W-1:0]      rsp_avg_alpha;
   logic                 rsp_frame_done;

   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_data  = '0;

   box_average_downscaler dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .req_alpha      (req_alpha),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_avg_red    (rsp_avg_red),
      .rsp_avg_green  (rsp_avg_green),
      .rsp_avg_blue   (rsp_avg_blue),
      .rsp_avg_alpha  (rsp_avg_alpha),
      .rsp_frame_done (rsp_frame_done),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Box walker: own copy of the registers and of the frame position.
   // ------------------------------------------------------------------
   logic [CFG_W-1:0] cfg_scale;
   logic [CFG_W-1:0] cfg_width;
   logic [CFG_W-1:0] cfg_height;

   int unsigned     col_sum [NUM_CH][MAX_WIDTH];
   longint unsigned pos_col, pos_row;
   longint unsigned box_x, x_start, x_edge;
   longint unsigned box_y, y_start, y_edge;

   pixel_type   pixel_queue[$];   // pixels waiting for the driver
   box_avg_type avg_expected[$];  // averages still owed by the block
   bit          pixel_busy = 1'b0;
   int          mismatches = 0;

   // Scale below 1.0 acts as exactly 1.0.
   function automatic longint unsigned eff_scale(input logic [CFG_W-1:0] raw);
      return (raw < bxd_pkg::SCALE_ONE) ? longint'(bxd_pkg::SCALE_ONE) : longint'(raw);
   endfunction

   function automatic longint unsigned clamp_dim(input logic [CFG_W-1:0] raw,
                                                 input int limit);
      if (raw == 0)
         return 1;
      return (raw > limit) ? longint'(limit) : longint'(raw);
   endfunction

   task automatic rewind_row();
      box_x   = 0;
      x_start = 0;
      x_edge  = eff_scale(cfg_scale);
   endtask

   task automatic rewind_frame();
      pos_col = 0;
      pos_row = 0;
      rewind_row();
      box_y   = 0;
      y_start = 0;
      y_edge  = eff_scale(cfg_scale);
   endtask

   task automatic apply_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CFG_W-1:0] value);
      case (idx)
         bxd_pkg::CSR_SCALE:  cfg_scale  = value;
         bxd_pkg::CSR_WIDTH:  cfg_width  = value;
         bxd_pkg::CSR_HEIGHT: cfg_height = value;
         default: ;
      endcase
      // any write, the spare index too, drops the partial frame
      rewind_frame();
   endtask

   // Advance the frame by one source pixel; queue the box average if the
   // pixel is the bottom-right corner of a whole box.
   task automatic accumulate_pixel(input pixel_type px);
      longint unsigned s, w, h, out_w, out_h, x_end, y_end, area;
      int unsigned     ch [NUM_CH];
      bit              box_opens;
      box_avg_type     avg;
      int              c;
      s     = eff_scale(cfg_scale);
      w     = clamp_dim(cfg_width, MAX_WIDTH);
      h     = clamp_dim(cfg_height, MAX_HEIGHT);
      out_w = (w << FRAC_BITS) / s;
      out_h = (h << FRAC_BITS) / s;
      x_end = x_edge >> FRAC_BITS;
      y_end = y_edge >> FRAC_BITS;
      ch[0] = px.red;
      ch[1] = px.green;
      ch[2] = px.blue;
      ch[3] = px.alpha;

      // pixels right of or below the last whole box go nowhere
      if (box_y < out_h && box_x < out_w && box_x < MAX_WIDTH) begin
         box_opens = (pos_col == x_start) && (pos_row == y_start);
         for (c = 0; c < NUM_CH; c++) begin
            if (box_opens)
               col_sum[c][box_x] = ch[c];
            else
               col_sum[c][box_x] += ch[c];
         end
         if (pos_col + 1 == x_end) begin
            if (pos_row + 1 == y_end) begin
               area = (x_end - x_start) * (y_end - y_start);
               if (area == 0)
                  area = 1;
               avg.out_x      = OUT_XY_W'(box_x);
               avg.out_y      = OUT_XY_W'(box_y);
               avg.red        = CH_W'(col_sum[0][box_x] / area);
               avg.green      = CH_W'(col_sum[1][box_x] / area);
               avg.blue       = CH_W'(col_sum[2][box_x] / area);
               avg.alpha      = CH_W'(col_sum[3][box_x] / area);
               avg.frame_done = (box_y + 1 == out_h) && (box_x + 1 == out_w);
               avg_expected.push_back(avg);
            end
            box_x++;
            x_start = x_end;
            x_edge += s;
         end
      end

      pos_col++;
      if (pos_col >= w) begin
         rewind_row();
         if (box_y < out_h && pos_row + 1 == y_end) begin
            box_y++;
            y_start = y_end;
            y_edge += s;
         end
         pos_col = 0;
         pos_row++;
         if (pos_row >= h)
            rewind_frame();
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic pixel_type make_pixel(input pixel_style_type style);
      pixel_type p;
      p.hold_for_drain = ($urandom_range(0, 63) == 0);
      case (style)
         PIX_RAILS: begin
            p.red   = $urandom_range(0, 1) ? 8'hff : 8'h00;
            p.green = $urandom_range(0, 1) ? 8'hff : 8'h00;
            p.blue  = $urandom_range(0, 1) ? 8'hff : 8'h00;
            p.alpha = $urandom_range(0, 1) ? 8'hff : 8'h00;
         end
         PIX_WHITE: begin
            p.red   = 8'hff;
            p.green = 8'hff;
            p.blue  = 8'hff;
            p.alpha = 8'hff;
         end
         default: begin
            p.red   = CH_W'($urandom);
            p.green = CH_W'($urandom);
            p.blue  = CH_W'($urandom);
            p.alpha = CH_W'($urandom);
         end
      endcase
      return p;
   endfunction

   task automatic push_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                             input logic [CH_W-1:0] b, input logic [CH_W-1:0] a);
      pixel_type p;
      p.red            = r;
      p.green          = g;
      p.blue           = b;
      p.alpha          = a;
      p.hold_for_drain = 1'b0;
      pixel_queue.push_back(p);
   endtask

   task automatic push_random(input int n, input pixel_style_type style);
      repeat (n) pixel_queue.push_back(make_pixel(style));
   endtask

   // Block until every pixel has gone in and every average has come out,
   // then give the pipeline time to retire pixels that owe no result.
   task automatic wait_idle();
      while (pixel_queue.size() != 0 || pixel_busy || avg_expected.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      apply_csr(idx, value);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic [CFG_W-1:0] scale,
                            input logic [CFG_W-1:0] w,
                            input logic [CFG_W-1:0] h);
      wait_idle();
      csr_write(bxd_pkg::CSR_SCALE, scale);
      csr_write(bxd_pkg::CSR_WIDTH, w);
      csr_write(bxd_pkg::CSR_HEIGHT, h);
   endtask

   // ------------------------------------------------------------------
   // Sequence: reset, directed frames, large frames, random frames.
   // ------------------------------------------------------------------
   initial begin
      int unsigned     scale, wid, hgt, npix, random_pixels;
      longint unsigned ow, oh;
      pixel_style_type style;
      cfg_scale  = bxd_pkg::RESET_SCALE;
      cfg_width  = bxd_pkg::RESET_WIDTH;
      cfg_height = bxd_pkg::RESET_HEIGHT;
      foreach (col_sum[c, x])
         col_sum[c][x] = 0;
      rewind_frame();
      random_pixels = 0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset registers: 2.0 over 640x480, first box closes on row one
      push_random(660, PIX_NOISE);

      // unit scale: every pixel is its own box; the last two wrap into
      // a fresh frame
      configure(bxd_pkg::SCALE_ONE, CFG_W'(3), CFG_W'(2));
      push_pixel(8'h00, 8'h00, 8'h00, 8'h00);
      push_pixel(8'hff, 8'hff, 8'hff, 8'hff);
      push_pixel(8'haa, 8'h55, 8'h0f, 8'hf0);
      push_pixel(8'h55, 8'haa, 8'hf0, 8'h0f);
      push_pixel(8'h01, 8'h02, 8'h04, 8'h08);
      push_pixel(8'hfe, 8'hfd, 8'hfb, 8'hf7);
      push_pixel(8'h10, 8'h20, 8'h40, 8'h80);
      push_pixel(8'h7f, 8'hbf, 8'hdf, 8'hef);

      // scale below one, zero width and height clamp to a 1x1 image
      configure('0, '0, '0);
      push_pixel(8'h33, 8'hcc, 8'h00, 8'hff);
      push_pixel(8'hcc, 8'h33, 8'hff, 8'h00);

      // box larger than the image: nothing comes out
      configure(CFG_W'(1024), CFG_W'(3), CFG_W'(3));
      push_random(4, PIX_NOISE);

      // write to the spare index in the middle of a box drops the box
      configure(bxd_pkg::RESET_SCALE, CFG_W'(4), CFG_W'(4));
      push_random(6, PIX_NOISE);
      wait_idle();
      csr_write(CSR_SPARE, CFG_W'($urandom));
      push_random(16, PIX_RAILS);

      // fractional scale 1.5: uneven boxes plus a dead column and row;
      // hold one pixel until the output side is empty
      configure(CFG_W'(384), CFG_W'(7), CFG_W'(5));
      push_random(35, PIX_NOISE);
      pixel_queue[20].hold_for_drain = 1'b1;

      // 16.0 with a trailing row that belongs to no box; full-scale pixels
      // give the largest sums of a 16x16 box
      configure(CFG_W'(4096), CFG_W'(16), CFG_W'(17));
      push_random(272, PIX_WHITE);

      // widest row: clamped to the column memory, cut short by the next write
      configure(bxd_pkg::SCALE_ONE, '1, CFG_W'(1));
      push_random(64, PIX_NOISE);

      // tallest column, scale below one again, cut short as well
      configure(CFG_W'(100), CFG_W'(1), '1);
      push_random(64, PIX_NOISE);

      // random frames, mostly small boxes, some partial to force restarts
      while (random_pixels < RANDOM_PIXELS) begin
         case ($urandom_range(0, 9))
            0, 1:    scale = $urandom_range(0, 255);
            2:       scale = $urandom_range(1024, 8191);
            default: scale = $urandom_range(256, 1023);
         endcase
         wid = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 24);
         hgt = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 24);
         ow  = (clamp_dim(CFG_W'(wid), MAX_WIDTH) << FRAC_BITS) / eff_scale(CFG_W'(scale));
         oh  = (clamp_dim(CFG_W'(hgt), MAX_HEIGHT) << FRAC_BITS) / eff_scale(CFG_W'(scale));
         npix = 32'(clamp_dim(CFG_W'(wid), MAX_WIDTH) * clamp_dim(CFG_W'(hgt), MAX_HEIGHT)
                    * $urandom_range(1, 2));
         if ($urandom_range(0, 3) == 0)
            npix = $urandom_range(1, npix);
         style = pixel_style_type'($urandom_range(0, 4) == 0 ? PIX_RAILS : PIX_NOISE);
         configure(CFG_W'(scale), CFG_W'(wid), CFG_W'(hgt));
         push_random(npix, style);
         // frames that produce nothing only walk the counters
         if (ow != 0 && oh != 0)
            random_pixels += npix;
      end

      wait_idle();
      if (mismatches == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

   // ------------------------------------------------------------------
   // Driver: bursts of pixel transfers separated by random gaps.
   // ------------------------------------------------------------------
   pixel_type cur_pixel;
   int        burst_left = 1;
   int        gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            accumulate_pixel(cur_pixel);
            pixel_busy = 1'b0;
         end

         if (req_valid && req_stall) begin
            // hold the stalled transfer as it is
         end else if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pixel_queue.size() != 0 &&
                      !(pixel_queue[0].hold_for_drain && avg_expected.size() != 0)) begin
            cur_pixel  = pixel_queue.pop_front();
            pixel_busy = 1'b1;
            req_red   <= cur_pixel.red;
            req_green <= cur_pixel.green;
            req_blue  <= cur_pixel.blue;
            req_alpha <= cur_pixel.alpha;
            req_valid <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 48);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Result side stall: switch to a randomly chosen pattern whenever the current one runs out.
   // ------------------------------------------------------------------
   stall_mode_type stall_mode = STALL_NONE;
   int unsigned    stall_left = 0;

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(20, 300);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_SOME: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_MOST: rsp_stall <= ($urandom_range(0, 3) != 0);
         STALL_BEAT: rsp_stall <= stall_left[2];
         default:    rsp_stall <= 1'b0;
      endcase
   end

   // ------------------------------------------------------------------
   // Monitor: check each averaged pixel against the oldest one owed.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      box_avg_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (avg_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("tb_top: unexpected result x=%0d y=%0d rgba=%0d,%0d,%0d,%0d last=%0b",
                        rsp_out_x, rsp_out_y, rsp_avg_red, rsp_avg_green,
                        rsp_avg_blue, rsp_avg_alpha, rsp_frame_done);
         end else begin
            want = avg_expected.pop_front();
            if (rsp_out_x !== want.out_x || rsp_out_y !== want.out_y ||
                rsp_avg_red !== want.red || rsp_avg_green !== want.green ||
                rsp_avg_blue !== want.blue || rsp_avg_alpha !== want.alpha ||
                rsp_frame_done !== want.frame_done) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display({"tb_top: mismatch expected x=%0d y=%0d rgba=%0d,%0d,%0d,%0d ",
                            "last=%0b, got x=%0d y=%0d rgba=%0d,%0d,%0d,%0d last=%0b"},
                           want.out_x, want.out_y, want.red, want.green, want.blue,
                           want.alpha, want.frame_done, rsp_out_x, rsp_out_y,
                           rsp_avg_red, rsp_avg_green, rsp_avg_blue, rsp_avg_alpha,
                           rsp_frame_done);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: stop a run that has gone quiet on every channel.
   // ------------------------------------------------------------------
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
